// ===== hw/rtl/utf8d_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
package utf8d_pkg;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_GATHER = 2'd1,
      MODE_SKIP   = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      KIND_CODE      = 2'd0,
      KIND_INVALID   = 2'd1,
      KIND_SEPARATOR = 2'd2
   } kind_type;

   localparam logic [20:0] SEPARATOR_VALUE = 21'h110000;
   localparam logic [7:0]  RECORD_SEP_BYTE = 8'hFF;
   localparam logic [7:0]  COUNT_MAX       = 8'hFF;

   typedef struct packed {
      logic [20:0] char_value;
      kind_type    result_kind;
      logic [7:0]  byte_count;
      logic        last_of_run;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } push_type;

endpackage

// ===== hw/rtl/utf8d_front.sv =====
// Front end: accepts bytes, tracks sequence state and emits up to two results per byte.
module utf8d_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [7:0]           data_byte,
   input  logic                 end_of_buffer,
   input  logic                 room,
   output utf8d_pkg::push_type  push
);

   utf8d_pkg::mode_type mode_ff, mode_in;
   logic [1:0]          need_ff, need_in;
   logic [20:0]         partial_ff, partial_in;
   logic [7:0]          cnt_ff, cnt_in;

   logic                accept;
   logic                cont;

   logic                sb_emit;
   utf8d_pkg::result_type sb_res;
   utf8d_pkg::mode_type sb_mode;
   logic [1:0]          sb_need;
   logic [20:0]         sb_val;
   logic [7:0]          sb_cnt;

   logic                e0_emit;
   logic                e1_emit;
   utf8d_pkg::result_type e0_res;
   logic [20:0]         val_g;
   logic [7:0]          cnt_g;
   logic [1:0]          need_g;
   logic [7:0]          cnt_s;

   assign in_ready = room;
   assign accept   = in_valid & in_ready;
   assign cont     = (data_byte[7:6] == 2'b10);

   always_comb begin
      sb_emit = 1'b1;
      sb_res  = '{char_value: '0, result_kind: utf8d_pkg::KIND_INVALID,
                  byte_count: 8'd1, last_of_run: 1'b0};
      sb_mode = utf8d_pkg::MODE_IDLE;
      sb_need = 2'd0;
      sb_val  = '0;
      sb_cnt  = '0;
      priority if (data_byte[7:3] == 5'b11111) begin
         if (data_byte == utf8d_pkg::RECORD_SEP_BYTE) begin
            sb_res.char_value  = utf8d_pkg::SEPARATOR_VALUE;
            sb_res.result_kind = utf8d_pkg::KIND_SEPARATOR;
         end
      end else if (!data_byte[7]) begin
         sb_res.char_value  = {13'd0, data_byte};
         sb_res.result_kind = utf8d_pkg::KIND_CODE;
      end else if (cont) begin
         if (!end_of_buffer) begin
            sb_emit = 1'b0;
            sb_mode = utf8d_pkg::MODE_SKIP;
            sb_cnt  = 8'd1;
         end
      end else begin
         if (!end_of_buffer) begin
            sb_emit = 1'b0;
            sb_mode = utf8d_pkg::MODE_GATHER;
            sb_cnt  = 8'd1;
            priority if (!data_byte[5]) begin
               sb_need = 2'd1;
               sb_val  = {16'd0, data_byte[4:0]};
            end else if (!data_byte[4]) begin
               sb_need = 2'd2;
               sb_val  = {17'd0, data_byte[3:0]};
            end else begin
               sb_need = 2'd3;
               sb_val  = {18'd0, data_byte[2:0]};
            end
         end
      end
   end

   always_comb begin
      val_g      = {partial_ff[14:0], data_byte[5:0]};
      cnt_g      = cnt_ff + 8'd1;
      need_g     = need_ff - 2'd1;
      cnt_s      = (cnt_ff == utf8d_pkg::COUNT_MAX) ? cnt_ff : cnt_ff + 8'd1;
      e0_emit    = 1'b0;
      e1_emit    = 1'b0;
      e0_res     = '{char_value: '0, result_kind: utf8d_pkg::KIND_INVALID,
                     byte_count: cnt_ff, last_of_run: 1'b0};
      mode_in    = mode_ff;
      need_in    = need_ff;
      partial_in = partial_ff;
      cnt_in     = cnt_ff;
      unique case (mode_ff)
         utf8d_pkg::MODE_GATHER: begin
            if (cont) begin
               if (need_g == 2'd0) begin
                  e0_emit            = 1'b1;
                  e0_res.char_value  = val_g;
                  e0_res.result_kind = utf8d_pkg::KIND_CODE;
                  e0_res.byte_count  = cnt_g;
                  mode_in            = utf8d_pkg::MODE_IDLE;
                  need_in            = 2'd0;
                  partial_in         = '0;
                  cnt_in             = '0;
               end else if (end_of_buffer) begin
                  e0_emit           = 1'b1;
                  e0_res.byte_count = cnt_g;
                  mode_in           = utf8d_pkg::MODE_IDLE;
                  need_in           = 2'd0;
                  partial_in        = '0;
                  cnt_in            = '0;
               end else begin
                  need_in    = need_g;
                  partial_in = val_g;
                  cnt_in     = cnt_g;
               end
            end else begin
               e0_emit    = 1'b1;
               e1_emit    = sb_emit;
               mode_in    = sb_mode;
               need_in    = sb_need;
               partial_in = sb_val;
               cnt_in     = sb_cnt;
            end
         end
         utf8d_pkg::MODE_SKIP: begin
            if (cont) begin
               if (end_of_buffer) begin
                  e0_emit           = 1'b1;
                  e0_res.byte_count = cnt_s;
                  mode_in           = utf8d_pkg::MODE_IDLE;
                  need_in           = 2'd0;
                  partial_in        = '0;
                  cnt_in            = '0;
               end else begin
                  cnt_in = cnt_s;
               end
            end else begin
               e0_emit    = 1'b1;
               e1_emit    = sb_emit;
               mode_in    = sb_mode;
               need_in    = sb_need;
               partial_in = sb_val;
               cnt_in     = sb_cnt;
            end
         end
         default: begin
            e1_emit    = sb_emit;
            mode_in    = sb_mode;
            need_in    = sb_need;
            partial_in = sb_val;
            cnt_in     = sb_cnt;
         end
      endcase
   end

   always_comb begin
      push.count = 2'd0;
      push.r0    = e0_res;
      push.r1    = sb_res;
      if (accept) begin
         priority if (e0_emit && e1_emit) begin
            push.count          = 2'd2;
            push.r1.last_of_run = 1'b1;
         end else if (e0_emit) begin
            push.count          = 2'd1;
            push.r0.last_of_run = 1'b1;
         end else if (e1_emit) begin
            push.count          = 2'd1;
            push.r0             = sb_res;
            push.r0.last_of_run = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= utf8d_pkg::MODE_IDLE;
         need_ff    <= '0;
         partial_ff <= '0;
         cnt_ff     <= '0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         need_ff    <= need_in;
         partial_ff <= partial_in;
         cnt_ff     <= cnt_in;
      end
   end

endmodule

// ===== hw/rtl/utf8d_fifo.sv =====
// Result queue between front and back end: up to two writes and one read per cycle.
module utf8d_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  utf8d_pkg::push_type    push,
   output logic                   room,
   input  logic                   pop,
   output logic                   not_empty,
   output utf8d_pkg::result_type  head
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   utf8d_pkg::result_type mem [DEPTH];
   logic [AW-1:0] wptr_ff, wptr_in;
   logic [AW-1:0] rptr_ff, rptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign room      = (count_ff <= CW'(DEPTH - 2));
   assign not_empty = (count_ff != '0);
   assign head      = mem[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff + AW'(push.count);
      rptr_in  = rptr_ff + AW'(pop);
      count_in = count_ff + CW'(push.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wptr_ff] <= push.r0;
      end
      if (push.count == 2'd2) begin
         mem[wptr_ff + AW'(1)] <= push.r1;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("result queue count exceeds depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("result queue read while empty");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> room)
      else $error("result queue written without room");

   a_last_marks: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (push.r1.last_of_run && !push.r0.last_of_run))
      else $error("two-result transaction has wrong last marks");

endmodule

// ===== hw/rtl/utf8d_back.sv =====
// Back end: drains the result queue into the output register.
module utf8d_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   not_empty,
   input  utf8d_pkg::result_type  head,
   output logic                   pop,
   output logic                   out_valid,
   input  logic                   out_ready,
   output utf8d_pkg::result_type  out_res
);

   logic                  valid_ff, valid_in;
   utf8d_pkg::result_type res_ff;

   assign pop       = not_empty & (~valid_ff | out_ready);
   assign valid_in  = pop | (valid_ff & ~out_ready);
   assign out_valid = valid_ff;
   assign out_res   = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         res_ff <= head;
      end
   end

endmodule

// ===== hw/rtl/utf8_stream_decoder_top.sv =====
// Top level of the UTF-8 stream decoder.
//
// Input channel req_*: one raw byte per transaction in req_tdata[7:0];
// req_tlast marks the last byte of a buffer and closes any open sequence
// or stray-continuation run on that byte.
// Result channel rsp_*: one decoded result per transaction; code point and
// byte count in rsp_tdata, result kind in rsp_tuser, and rsp_tlast on the
// final result caused by an input byte.
// Each byte yields zero, one or two results. The results of an accepted
// byte are written into the result queue and then loaded into the output
// register before they show on rsp_tvalid, the first ahead of the second.
// Throughput: one byte per cycle while req_tready is high. The front end needs two free queue
// slots to take a byte; the output register drains one result per cycle while rsp_tready is
// high, so bytes that yield two results are absorbed by the FIFO_DEPTH-entry queue.
// Reset clears the decode state, empties the queue and clears the output valid flag.
// When rsp_tready is low the output register holds, the queue fills and
// req_tready drops once fewer than two slots remain.
module utf8_stream_decoder_top #(
   parameter int FIFO_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] data_byte
   input  logic        req_tlast,  // end_of_buffer
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [20:0] char_value, [28:21] byte_count, [31:29] zero
   output logic [1:0]  rsp_tuser,  // [1:0] result_kind
   output logic        rsp_tlast   // last_of_run
);

   utf8d_pkg::push_type   push;
   utf8d_pkg::result_type head;
   utf8d_pkg::result_type out_res;
   logic                  room;
   logic                  pop;
   logic                  not_empty;

   utf8d_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .data_byte     (req_tdata),
      .end_of_buffer (req_tlast),
      .room          (room),
      .push          (push)
   );

   utf8d_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   utf8d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res)
   );

   assign rsp_tdata = {3'd0, out_res.byte_count, out_res.char_value};
   assign rsp_tuser = out_res.result_kind;
   assign rsp_tlast = out_res.last_of_run;

endmodule
